@@ design/touch_point_tracker_defines.svh @@
// Assertion helpers for touch_point_tracker.
`ifndef TOUCH_POINT_TRACKER_DEFINES_SVH
`define TOUCH_POINT_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define TPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("touch_point_tracker: check failed");

// Next-cycle implication.
`define TPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("touch_point_tracker: check failed");

`endif

@@ design/tpt_pkg.sv @@
`timescale 1ns / 1ps

package tpt_pkg;

    // Widest values over the parameter ranges; narrower configs zero-extend.
    localparam int IDX_MAX_W   = 6;
    localparam int COORD_MAX_W = 16;
    localparam int DIST_MAX_W  = 2 * COORD_MAX_W + 1;
    localparam int ID_MAX_W    = 16;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_MOVE    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_MOVE    = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // Search token walking the slot chain.
    typedef struct packed {
        logic                  vld;
        logic                  found;
        logic [IDX_MAX_W-1:0]  best_idx;
        logic [DIST_MAX_W-1:0] best_d;
        logic [ID_MAX_W-1:0]   best_id;
        logic                  free_found;
        logic [IDX_MAX_W-1:0]  free_idx;
    } t_token;

    // Slot update broadcast after a search.
    typedef struct packed {
        logic                   vld;
        t_op                    op;
        logic [IDX_MAX_W-1:0]   idx;
        logic [ID_MAX_W-1:0]    id;
        logic [COORD_MAX_W-1:0] x;
        logic [COORD_MAX_W-1:0] y;
    } t_cmd;

endpackage

@@ design/tpt_cell.sv @@
`timescale 1ns / 1ps

module tpt_cell #(
    parameter int CW    = 12,
    parameter int IDW   = 8,
    parameter int INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [CW-1:0]  i_qx,
    input  logic [CW-1:0]  i_qy,
    input  tpt_pkg::t_token i_tok,
    output tpt_pkg::t_token o_tok,
    input  tpt_pkg::t_cmd  i_cmd
);
    import tpt_pkg::*;

    logic           r_valid;
    logic [IDW-1:0] r_id;
    logic [CW-1:0]  r_x;
    logic [CW-1:0]  r_y;
    t_token         r_tok;
    t_token         n_tok;

    logic [CW-1:0]   w_dx;
    logic [CW-1:0]   w_dy;
    logic [2*CW-1:0] w_sx;
    logic [2*CW-1:0] w_sy;
    logic [2*CW:0]   w_d;
    logic            w_better;
    logic            w_hit;

    always_comb begin
        w_dx = (i_qx >= r_x) ? (i_qx - r_x) : (r_x - i_qx);
        w_dy = (i_qy >= r_y) ? (i_qy - r_y) : (r_y - i_qy);
        w_sx = w_dx * w_dx;
        w_sy = w_dy * w_dy;
        w_d  = {1'b0, w_sx} + {1'b0, w_sy};
        // strict less-than keeps ties on the lower slot
        w_better = r_valid && (!i_tok.found || (DIST_MAX_W'(w_d) < i_tok.best_d));

        n_tok = i_tok;
        if (w_better) begin
            n_tok.found    = 1'b1;
            n_tok.best_idx = IDX_MAX_W'(INDEX);
            n_tok.best_d   = DIST_MAX_W'(w_d);
            n_tok.best_id  = ID_MAX_W'(r_id);
        end
        if (!i_tok.free_found && !r_valid) begin
            n_tok.free_found = 1'b1;
            n_tok.free_idx   = IDX_MAX_W'(INDEX);
        end
    end

    assign w_hit = i_cmd.vld && (i_cmd.idx == IDX_MAX_W'(INDEX));
    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_hit) begin
            case (i_cmd.op)
                OP_PRESS:   r_valid <= 1'b1;
                OP_RELEASE: r_valid <= 1'b0;
                default:    r_valid <= r_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && (i_cmd.op == OP_PRESS)) begin
            r_id <= i_cmd.id[IDW-1:0];
        end
        if (w_hit && ((i_cmd.op == OP_PRESS) || (i_cmd.op == OP_MOVE))) begin
            r_x <= i_cmd.x[CW-1:0];
            r_y <= i_cmd.y[CW-1:0];
        end
    end

endmodule

@@ design/touch_point_tracker.sv @@
// Input beat to result beat: input registers, a token register in each slot cell, the
// finished-token register, then the output register. One event at a time: the search token
// walks the slot chain one cell per cycle, and the next event waits for the commit.
// Reset (i_rst_n low, synchronous): all slots free, next id 0, no result pending.
`timescale 1ns / 1ps
`include "touch_point_tracker_defines.svh"

module touch_point_tracker #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 12,
    parameter int ID_BITS    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_track_id,
    output logic [11:0] o_out_x,
    output logic [11:0] o_out_y,
    output logic [1:0]  o_status
);
    import tpt_pkg::*;

    // Coordinates use only the low COORD_BITS of the 12-bit ports, capped at 12.
    localparam int CW = (COORD_BITS < 12) ? COORD_BITS : 12;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_POST
    } t_state;

    t_state            r_state;
    t_kind             r_kind;
    logic [CW-1:0]     r_qx;
    logic [CW-1:0]     r_qy;
    logic              r_start;
    t_token            r_tok;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [ID_BITS-1:0] r_next_id;
    logic [ID_BITS-1:0] n_next_id;

    t_token             w_tok0;
    t_token             w_tok [0:MAX_TRACKS];
    logic [ID_BITS-1:0] w_id;
    logic [1:0]         w_status;
    logic               w_out_free;

    // Fresh token into the head of the chain: nothing found yet.
    always_comb begin
        w_tok0     = '0;
        w_tok0.vld = r_start;
    end
    assign w_tok[0] = w_tok0;

    // One cell per slot; each compares its own track against the token and
    // passes the running best (and lowest free slot) on to its neighbor.
    for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
        tpt_cell #(
            .CW    (CW),
            .IDW   (ID_BITS),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_qx    (r_qx),
            .i_qy    (r_qy),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_cmd   (r_cmd)
        );
    end

    assign o_ready    = (r_state == S_IDLE);
    assign w_out_free = !o_valid || i_ready;

    // Decide the result and the slot update from the finished token.
    always_comb begin
        n_cmd     = '0;
        n_next_id = r_next_id;
        w_id      = '0;
        w_status  = ST_OK;
        case (r_kind)
            KIND_PRESS: begin
                if (r_tok.free_found) begin
                    w_id      = r_next_id;
                    n_cmd.vld = 1'b1;
                    n_cmd.op  = OP_PRESS;
                    n_cmd.idx = r_tok.free_idx;
                    n_cmd.id  = ID_MAX_W'(r_next_id);
                    n_cmd.x   = COORD_MAX_W'(r_qx);
                    n_cmd.y   = COORD_MAX_W'(r_qy);
                    n_next_id = r_next_id + 1'b1;
                end else begin
                    w_status = ST_FULL;
                end
            end
            KIND_MOVE, KIND_RELEASE: begin
                if (r_tok.found) begin
                    // id taken from the slot before it is freed
                    w_id      = r_tok.best_id[ID_BITS-1:0];
                    n_cmd.vld = 1'b1;
                    n_cmd.op  = (r_kind == KIND_MOVE) ? OP_MOVE : OP_RELEASE;
                    n_cmd.idx = r_tok.best_idx;
                    n_cmd.x   = COORD_MAX_W'(r_qx);
                    n_cmd.y   = COORD_MAX_W'(r_qy);
                    if ((r_kind == KIND_RELEASE) && (w_id < r_next_id)) begin
                        n_next_id = w_id;
                    end
                end else begin
                    w_status = ST_NONE;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_cmd.vld <= 1'b0;
            r_next_id <= '0;
            o_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    // slot update from the last commit lands here
                    r_cmd.vld <= 1'b0;
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                    end
                    r_start <= i_valid;
                    if (i_valid) begin
                        r_kind  <= t_kind'(i_kind);
                        r_qx    <= i_pos_x[CW-1:0];
                        r_qy    <= i_pos_y[CW-1:0];
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_start   <= 1'b0;
                    r_cmd.vld <= 1'b0;
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                    end
                    if (w_tok[MAX_TRACKS].vld) begin
                        r_tok   <= w_tok[MAX_TRACKS];
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_start <= 1'b0;
                    // hold here until the output register can take the beat
                    if (w_out_free) begin
                        o_valid      <= 1'b1;
                        o_event_kind <= r_kind;
                        o_track_id   <= 8'(w_id);
                        o_out_x      <= 12'(r_qx);
                        o_out_y      <= 12'(r_qy);
                        o_status     <= w_status;
                        r_cmd        <= n_cmd;
                        r_next_id    <= n_next_id;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cmd.vld <= 1'b0;
                    end
                end
                default: begin
                    r_start   <= 1'b0;
                    r_cmd.vld <= 1'b0;
                    r_state   <= S_IDLE;
                end
            endcase
        end
    end

    `TPT_ASSERT_SAME(a_tok_only_in_search, w_tok[MAX_TRACKS].vld, r_state == S_SEARCH)
    `TPT_ASSERT_SAME(a_cmd_lands_idle, r_cmd.vld, r_state == S_IDLE)
    `TPT_ASSERT_NEXT(a_post_loads_out, r_state == S_POST && w_out_free, o_valid)
    `TPT_ASSERT_SAME(a_full_only_press, o_valid && o_status == ST_FULL, o_event_kind == KIND_PRESS)

endmodule
